// ===== sv/drrl_pkg.sv =====
package drrl_pkg;

    localparam int REGION_SLOTS = 64;
    localparam int SLOT_W       = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int COORD_W      = 11;
    localparam int IN_W         = 12;
    localparam int INDEX_W      = 6;
    localparam int CFG_IDX_W    = 1;

    localparam logic [COORD_W-1:0] WIDTH_RESET  = COORD_W'(640);
    localparam logic [COORD_W-1:0] HEIGHT_RESET = COORD_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_ROTATE = 2'd1,
        ACT_MARK   = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef struct packed {
        logic [COORD_W-1:0] l;
        logic [COORD_W-1:0] t;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] b;
        logic               redraw;
    } t_rect;

    typedef struct packed {
        logic load;
        logic scan;
        logic exec;
        logic read;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clip_empty;
        logic last;
        logic all_done;
    } t_stat;

    function automatic logic rect_zero(input t_rect e);
        return (e.l == '0) && (e.t == '0) && (e.r == '0) && (e.b == '0);
    endfunction

endpackage

// ===== sv/drrl_ctrl.sv =====
module drrl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [1:0]      i_action,
    input  drrl_pkg::t_stat i_stat,
    output logic            busy,
    output logic            o_strobe,
    output drrl_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EXEC = 4'b0100,
        ST_READ = 4'b1000
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic           r_strobe;
    drrl_pkg::t_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    w_cmd.load = 1'b1;
                    case (drrl_pkg::t_action'(i_action))
                        drrl_pkg::ACT_ADD:  n_state = ST_SCAN;
                        drrl_pkg::ACT_READ: n_state = ST_READ;
                        default:            n_state = ST_EXEC;
                    endcase
                end
            end
            ST_SCAN: begin
                w_cmd.scan = 1'b1;
                if (i_stat.clip_empty || i_stat.last || i_stat.all_done) begin
                    w_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_EXEC: begin
                w_cmd.exec = 1'b1;
                w_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_READ: begin
                w_cmd.read = 1'b1;
                w_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_cmd.emit;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_cmd    = w_cmd;

endmodule

// ===== sv/drrl_datapath.sv =====
module drrl_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [drrl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [drrl_pkg::COORD_W-1:0]   i_cfg_data,
    input  logic [1:0]                     i_action,
    input  logic [drrl_pkg::IN_W-1:0]      i_left,
    input  logic [drrl_pkg::IN_W-1:0]      i_top,
    input  logic [drrl_pkg::IN_W-1:0]      i_right,
    input  logic [drrl_pkg::IN_W-1:0]      i_bottom,
    input  logic                           i_always_redraw,
    input  logic [drrl_pkg::INDEX_W-1:0]   i_entry_index,
    input  drrl_pkg::t_cmd                 i_cmd,
    output drrl_pkg::t_stat                o_stat,
    output logic [1:0]                     o_status,
    output logic                           o_entry_used,
    output logic [drrl_pkg::COORD_W-1:0]   o_entry_left,
    output logic [drrl_pkg::COORD_W-1:0]   o_entry_top,
    output logic [drrl_pkg::COORD_W-1:0]   o_entry_right,
    output logic [drrl_pkg::COORD_W-1:0]   o_entry_bottom,
    output logic                           o_entry_redraw
);

    localparam int SLOTS = drrl_pkg::REGION_SLOTS;
    localparam int SW    = drrl_pkg::SLOT_W;
    localparam int CW    = drrl_pkg::COORD_W;

    logic [CW-1:0]     r_width;
    logic [CW-1:0]     r_height;
    logic              r_cur;
    logic [SLOTS-1:0]  r_valid [2];
    drrl_pkg::t_action r_act;
    drrl_pkg::t_rect   r_clip;
    logic              r_clip_empty;
    logic [SW-1:0]     r_idx;
    logic              r_in_range;
    logic [1:0]        r_done;
    drrl_pkg::t_rect   r_rdata [2];

    logic [1:0]        r_status;
    drrl_pkg::t_rect   r_entry;
    logic              r_used;

    logic signed [CW+1:0] w_l;
    logic signed [CW+1:0] w_t;
    logic signed [CW+1:0] w_r;
    logic signed [CW+1:0] w_b;
    logic signed [CW+1:0] w_ws;
    logic signed [CW+1:0] w_hs;
    drrl_pkg::t_rect      w_clip;
    logic                 w_clip_empty;

    drrl_pkg::t_rect  w_e      [2];
    drrl_pkg::t_rect  w_merged [2];
    logic [1:0]       w_empty;
    logic [1:0]       w_inter;
    logic [1:0]       w_match;
    logic [1:0]       w_hit;

    logic [1:0]       w_we;
    logic [SW-1:0]    w_waddr;
    drrl_pkg::t_rect  w_wdata [2];
    logic [SW-1:0]    w_raddr;
    logic [SW-1:0]    w_load_addr;
    drrl_pkg::t_rect  w_full;
    drrl_pkg::t_rect  w_rd_e;
    logic             w_rd_used;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= drrl_pkg::WIDTH_RESET;
            r_height <= drrl_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (drrl_pkg::t_cfg_reg'(i_cfg_index))
                drrl_pkg::REG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                drrl_pkg::REG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_ws = $signed({2'b00, r_width});
        w_hs = $signed({2'b00, r_height});
        w_l  = $signed({i_left[drrl_pkg::IN_W-1], i_left});
        w_t  = $signed({i_top[drrl_pkg::IN_W-1], i_top});
        w_r  = $signed({i_right[drrl_pkg::IN_W-1], i_right});
        w_b  = $signed({i_bottom[drrl_pkg::IN_W-1], i_bottom});
        if (w_l < 0) w_l = '0;
        if (w_t < 0) w_t = '0;
        if (w_r > w_ws) w_r = w_ws;
        if (w_b > w_hs) w_b = w_hs;
        w_clip_empty  = (w_l >= w_r) || (w_t >= w_b);
        w_clip.l      = w_l[CW-1:0];
        w_clip.t      = w_t[CW-1:0];
        w_clip.r      = w_r[CW-1:0];
        w_clip.b      = w_b[CW-1:0];
        w_clip.redraw = i_always_redraw;
    end

    assign w_load_addr = (drrl_pkg::t_action'(i_action) == drrl_pkg::ACT_READ)
                         ? SW'(i_entry_index) : '0;
    assign w_raddr     = i_cmd.load ? w_load_addr : SW'(r_idx + 1'b1);

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            w_e[j]     = r_rdata[r_cur ^ j[0]];
            w_empty[j] = !r_valid[r_cur ^ j[0]][r_idx] || drrl_pkg::rect_zero(w_e[j]);
            w_inter[j] = (w_e[j].r >= r_clip.l) && (w_e[j].l < r_clip.r) &&
                         (w_e[j].b >= r_clip.t) && (w_e[j].t < r_clip.b);
            w_match[j] = !r_clip_empty && !r_done[j] && (w_empty[j] || w_inter[j]);
            w_hit[j]   = i_cmd.scan && w_match[j];
            w_merged[j].l      = (r_clip.l < w_e[j].l) ? r_clip.l : w_e[j].l;
            w_merged[j].t      = (r_clip.t < w_e[j].t) ? r_clip.t : w_e[j].t;
            w_merged[j].r      = (r_clip.r > w_e[j].r) ? r_clip.r : w_e[j].r;
            w_merged[j].b      = (r_clip.b > w_e[j].b) ? r_clip.b : w_e[j].b;
            w_merged[j].redraw = r_clip.redraw | w_e[j].redraw;
        end
    end

    always_comb begin
        w_full.l      = '0;
        w_full.t      = '0;
        w_full.r      = r_width;
        w_full.b      = r_height;
        w_full.redraw = 1'b1;
        w_waddr       = i_cmd.exec ? '0 : r_idx;
        for (int g = 0; g < 2; g++) begin
            if (i_cmd.exec) begin
                w_we[g]    = (r_act == drrl_pkg::ACT_MARK) && (g[0] == r_cur);
                w_wdata[g] = w_full;
            end else begin
                w_we[g]    = w_hit[g[0] ^ r_cur];
                w_wdata[g] = w_empty[g[0] ^ r_cur] ? r_clip : w_merged[g[0] ^ r_cur];
            end
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_bank
        drrl_pkg::t_rect mem [SLOTS];

        always_ff @(posedge i_clk) begin
            if (w_we[g]) begin
                mem[w_waddr] <= w_wdata[g];
            end
            r_rdata[g] <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= 1'b0;
            r_valid[0] <= '0;
            r_valid[1] <= '0;
        end else if (i_cmd.exec) begin
            if (r_act == drrl_pkg::ACT_ROTATE) begin
                r_valid[~r_cur] <= '0;
                r_cur           <= ~r_cur;
            end else if (r_act == drrl_pkg::ACT_MARK) begin
                r_valid[r_cur] <= SLOTS'(1);
            end
        end else begin
            for (int g = 0; g < 2; g++) begin
                if (w_we[g]) r_valid[g][w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else if (i_cmd.load) begin
            r_done <= '0;
        end else if (i_cmd.scan) begin
            r_done <= r_done | w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act        <= drrl_pkg::t_action'(i_action);
            r_clip       <= w_clip;
            r_clip_empty <= w_clip_empty;
            r_idx        <= w_load_addr;
            r_in_range   <= (32'(i_entry_index) < SLOTS);
        end else if (i_cmd.scan) begin
            r_idx <= SW'(r_idx + 1'b1);
        end
    end

    assign o_stat.clip_empty = r_clip_empty;
    assign o_stat.last       = (r_idx == SW'(SLOTS - 1));
    assign o_stat.all_done   = &(r_done | w_match);

    assign w_rd_e    = r_rdata[~r_cur];
    assign w_rd_used = r_in_range && r_valid[~r_cur][r_idx] && !drrl_pkg::rect_zero(w_rd_e);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= (i_cmd.scan && !r_clip_empty) ? ~(r_done | w_hit) : 2'b00;
            r_used   <= i_cmd.read && w_rd_used;
            r_entry  <= (i_cmd.read && w_rd_used) ? w_rd_e : '0;
        end
    end

    assign o_status       = r_status;
    assign o_entry_used   = r_used;
    assign o_entry_left   = r_entry.l;
    assign o_entry_top    = r_entry.t;
    assign o_entry_right  = r_entry.r;
    assign o_entry_bottom = r_entry.b;
    assign o_entry_redraw = r_entry.redraw;

endmodule

// ===== sv/dirty_rectangle_region_list.sv =====
// Channel   Handshake                    Payload
// -------   ---------------------------  ---------------------------------------------
// command   start, busy (start & !busy)  i_action, i_left/top/right/bottom,
//                                        i_always_redraw, i_entry_index
// result    o_strobe, one cycle          o_status, o_entry_used, o_entry_left/top/
//                                        right/bottom, o_entry_redraw
// config    i_cfg_valid, o_cfg_ready     i_cfg_index, i_cfg_data
//
// Add: busy while it scans, one slot a cycle (at most REGION_SLOTS slots) through the
// registered read port of each table; both tables scan together.
// Rotate, mark all, read: busy for one cycle. o_strobe follows in the next cycle.
// Rotate swaps the two table banks and clears per-slot valid bits, so no copy pass.
// Synchronous active-low reset empties both tables at once; no clearing pass.
// Results cannot be stalled; a new command is taken in the cycle o_strobe is high.
module dirty_rectangle_region_list (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_action,
    input  logic [drrl_pkg::IN_W-1:0]      i_left,
    input  logic [drrl_pkg::IN_W-1:0]      i_top,
    input  logic [drrl_pkg::IN_W-1:0]      i_right,
    input  logic [drrl_pkg::IN_W-1:0]      i_bottom,
    input  logic                           i_always_redraw,
    input  logic [drrl_pkg::INDEX_W-1:0]   i_entry_index,
    output logic                           o_strobe,
    output logic [1:0]                     o_status,
    output logic                           o_entry_used,
    output logic [drrl_pkg::COORD_W-1:0]   o_entry_left,
    output logic [drrl_pkg::COORD_W-1:0]   o_entry_top,
    output logic [drrl_pkg::COORD_W-1:0]   o_entry_right,
    output logic [drrl_pkg::COORD_W-1:0]   o_entry_bottom,
    output logic                           o_entry_redraw,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [drrl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [drrl_pkg::COORD_W-1:0]   i_cfg_data
);

    drrl_pkg::t_cmd  w_cmd;
    drrl_pkg::t_stat w_stat;

    drrl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_stat   (w_stat),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (w_cmd)
    );

    drrl_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_left          (i_left),
        .i_top           (i_top),
        .i_right         (i_right),
        .i_bottom        (i_bottom),
        .i_always_redraw (i_always_redraw),
        .i_entry_index   (i_entry_index),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_status        (o_status),
        .o_entry_used    (o_entry_used),
        .o_entry_left    (o_entry_left),
        .o_entry_top     (o_entry_top),
        .o_entry_right   (o_entry_right),
        .o_entry_bottom  (o_entry_bottom),
        .o_entry_redraw  (o_entry_redraw)
    );

endmodule

// ===== tb/dirty_rectangle_region_list_test.sv =====
module dirty_rectangle_region_list_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT   = 500000;
    localparam int PHASE_ITEMS = 70;
    localparam int PHASES      = 6;

    localparam logic [1:0] STATUS_CUR_FULL  = 2'b01;
    localparam logic [1:0] STATUS_PREV_FULL = 2'b10;

    typedef struct packed {
        drrl_pkg::t_action              action;
        logic [drrl_pkg::IN_W-1:0]      l;
        logic [drrl_pkg::IN_W-1:0]      t;
        logic [drrl_pkg::IN_W-1:0]      r;
        logic [drrl_pkg::IN_W-1:0]      b;
        logic                           redraw;
        logic [drrl_pkg::INDEX_W-1:0]   idx;
    } t_dirty_cmd;

    typedef struct packed {
        logic [1:0]      status;
        logic            used;
        drrl_pkg::t_rect region;
    } t_region_result;

    class t_region_scoreboard;
        drrl_pkg::t_rect              cur_tab[drrl_pkg::REGION_SLOTS];
        drrl_pkg::t_rect              prev_tab[drrl_pkg::REGION_SLOTS];
        logic [drrl_pkg::COORD_W-1:0] scr_w;
        logic [drrl_pkg::COORD_W-1:0] scr_h;
        t_region_result               pending[$];
        int                           mismatches;

        function new();
            foreach (cur_tab[i]) begin
                cur_tab[i]  = '0;
                prev_tab[i] = '0;
            end
            scr_w      = drrl_pkg::WIDTH_RESET;
            scr_h      = drrl_pkg::HEIGHT_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(drrl_pkg::t_cfg_reg idx, logic [drrl_pkg::COORD_W-1:0] data);
            if (idx == drrl_pkg::REG_SCREEN_WIDTH) begin
                scr_w = data;
            end else begin
                scr_h = data;
            end
        endfunction

        function bit slot_free(drrl_pkg::t_rect e);
            return e.l == '0 && e.t == '0 && e.r == '0 && e.b == '0;
        endfunction

        function bit insert_region(bit into_prev, drrl_pkg::t_rect c);
            drrl_pkg::t_rect tab[drrl_pkg::REGION_SLOTS];
            bit              full;
            if (into_prev) begin
                tab = prev_tab;
            end else begin
                tab = cur_tab;
            end
            full = 1'b1;
            for (int i = 0; i < drrl_pkg::REGION_SLOTS && full; i++) begin
                if (slot_free(tab[i])) begin
                    tab[i] = c;
                    full   = 1'b0;
                end else if (tab[i].r >= c.l && tab[i].l < c.r &&
                             tab[i].b >= c.t && tab[i].t < c.b) begin
                    if (c.l < tab[i].l) tab[i].l = c.l;
                    if (c.t < tab[i].t) tab[i].t = c.t;
                    if (c.r > tab[i].r) tab[i].r = c.r;
                    if (c.b > tab[i].b) tab[i].b = c.b;
                    tab[i].redraw = tab[i].redraw | c.redraw;
                    full = 1'b0;
                end
            end
            if (into_prev) begin
                prev_tab = tab;
            end else begin
                cur_tab = tab;
            end
            return full;
        endfunction

        function void note_command(t_dirty_cmd c);
            t_region_result  res;
            drrl_pkg::t_rect clip;
            int              cl;
            int              ct;
            int              cr;
            int              cb;
            res = '0;
            case (c.action)
                drrl_pkg::ACT_ADD: begin
                    cl = int'($signed(c.l));
                    ct = int'($signed(c.t));
                    cr = int'($signed(c.r));
                    cb = int'($signed(c.b));
                    if (cl < 0) cl = 0;
                    if (ct < 0) ct = 0;
                    if (cr > int'(scr_w)) cr = int'(scr_w);
                    if (cb > int'(scr_h)) cb = int'(scr_h);
                    if (cl < cr && ct < cb) begin
                        clip.l      = drrl_pkg::COORD_W'(cl);
                        clip.t      = drrl_pkg::COORD_W'(ct);
                        clip.r      = drrl_pkg::COORD_W'(cr);
                        clip.b      = drrl_pkg::COORD_W'(cb);
                        clip.redraw = c.redraw;
                        if (insert_region(1'b0, clip)) res.status = res.status | STATUS_CUR_FULL;
                        if (insert_region(1'b1, clip)) res.status = res.status | STATUS_PREV_FULL;
                    end
                end
                drrl_pkg::ACT_ROTATE: begin
                    prev_tab = cur_tab;
                    foreach (cur_tab[i]) cur_tab[i] = '0;
                end
                drrl_pkg::ACT_MARK: begin
                    foreach (cur_tab[i]) cur_tab[i] = '0;
                    cur_tab[0].r      = scr_w;
                    cur_tab[0].b      = scr_h;
                    cur_tab[0].redraw = 1'b1;
                end
                default: begin
                    if (int'(c.idx) < drrl_pkg::REGION_SLOTS && !slot_free(prev_tab[c.idx])) begin
                        res.used   = 1'b1;
                        res.region = prev_tab[c.idx];
                    end
                end
            endcase
            pending.push_back(res);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_result(t_region_result got);
            t_region_result want;
            if (pending.size() == 0) begin
                report("result strobe with no command outstanding");
                return;
            end
            want = pending.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("entry_used", got.used, want.used);
            compare_field("entry_left", got.region.l, want.region.l);
            compare_field("entry_top", got.region.t, want.region.t);
            compare_field("entry_right", got.region.r, want.region.r);
            compare_field("entry_bottom", got.region.b, want.region.b);
            compare_field("entry_redraw", got.region.redraw, want.region.redraw);
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n         = 1'b0;
    logic                           start           = 1'b0;
    logic                           busy;
    logic [1:0]                     i_action        = '0;
    logic [drrl_pkg::IN_W-1:0]      i_left          = '0;
    logic [drrl_pkg::IN_W-1:0]      i_top           = '0;
    logic [drrl_pkg::IN_W-1:0]      i_right         = '0;
    logic [drrl_pkg::IN_W-1:0]      i_bottom        = '0;
    logic                           i_always_redraw = 1'b0;
    logic [drrl_pkg::INDEX_W-1:0]   i_entry_index   = '0;
    logic                           o_strobe;
    logic [1:0]                     o_status;
    logic                           o_entry_used;
    logic [drrl_pkg::COORD_W-1:0]   o_entry_left;
    logic [drrl_pkg::COORD_W-1:0]   o_entry_top;
    logic [drrl_pkg::COORD_W-1:0]   o_entry_right;
    logic [drrl_pkg::COORD_W-1:0]   o_entry_bottom;
    logic                           o_entry_redraw;
    logic                           i_cfg_valid     = 1'b0;
    logic                           o_cfg_ready;
    logic [drrl_pkg::CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [drrl_pkg::COORD_W-1:0]   i_cfg_data      = '0;

    t_region_scoreboard sb;
    int                 cycle_count = 0;
    int                 idle_pct    = 0;
    int                 items_sent  = 0;
    t_dirty_cmd         seen_cmd;
    t_region_result     seen_result;

    dirty_rectangle_region_list DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_left         (i_left),
        .i_top          (i_top),
        .i_right        (i_right),
        .i_bottom       (i_bottom),
        .i_always_redraw(i_always_redraw),
        .i_entry_index  (i_entry_index),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_entry_used   (o_entry_used),
        .o_entry_left   (o_entry_left),
        .o_entry_top    (o_entry_top),
        .o_entry_right  (o_entry_right),
        .o_entry_bottom (o_entry_bottom),
        .o_entry_redraw (o_entry_redraw),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("dirty_rectangle_region_list_test failed");
            $finish;
        end else if (i_rst_n) begin
            if (o_strobe) begin
                seen_result.status        = o_status;
                seen_result.used          = o_entry_used;
                seen_result.region.l      = o_entry_left;
                seen_result.region.t      = o_entry_top;
                seen_result.region.r      = o_entry_right;
                seen_result.region.b      = o_entry_bottom;
                seen_result.region.redraw = o_entry_redraw;
                sb.check_result(seen_result);
            end
            if (start && !busy) begin
                seen_cmd.action = drrl_pkg::t_action'(i_action);
                seen_cmd.l      = i_left;
                seen_cmd.t      = i_top;
                seen_cmd.r      = i_right;
                seen_cmd.b      = i_bottom;
                seen_cmd.redraw = i_always_redraw;
                seen_cmd.idx    = i_entry_index;
                sb.note_command(seen_cmd);
            end
        end
    end

    function automatic t_dirty_cmd random_cmd();
        t_dirty_cmd c;
        c.action = drrl_pkg::t_action'($urandom_range(0, 3));
        c.l      = drrl_pkg::IN_W'($urandom);
        c.t      = drrl_pkg::IN_W'($urandom);
        c.r      = drrl_pkg::IN_W'($urandom);
        c.b      = drrl_pkg::IN_W'($urandom);
        c.redraw = 1'($urandom);
        c.idx    = drrl_pkg::INDEX_W'($urandom);
        return c;
    endfunction

    // hold start high across back-to-back transfers
    task send_cmd(t_dirty_cmd c);
        @(negedge i_clk);
        while (int'($urandom_range(0, 99)) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start           <= 1'b1;
        i_action        <= c.action;
        i_left          <= c.l;
        i_top           <= c.t;
        i_right         <= c.r;
        i_bottom        <= c.b;
        i_always_redraw <= c.redraw;
        i_entry_index   <= c.idx;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    task add_rect(int l, int t, int r, int b, bit rd);
        t_dirty_cmd c;
        c        = random_cmd();
        c.action = drrl_pkg::ACT_ADD;
        c.l      = drrl_pkg::IN_W'(l);
        c.t      = drrl_pkg::IN_W'(t);
        c.r      = drrl_pkg::IN_W'(r);
        c.b      = drrl_pkg::IN_W'(b);
        c.redraw = rd;
        send_cmd(c);
    endtask

    task plain_cmd(drrl_pkg::t_action act);
        t_dirty_cmd c;
        c        = random_cmd();
        c.action = act;
        send_cmd(c);
    endtask

    task read_slot(int idx);
        t_dirty_cmd c;
        c        = random_cmd();
        c.action = drrl_pkg::ACT_READ;
        c.idx    = drrl_pkg::INDEX_W'(idx);
        send_cmd(c);
    endtask

    task random_add();
        int w;
        int h;
        int x;
        int y;
        int sz;
        int pick;
        w    = int'(sb.scr_w);
        h    = int'(sb.scr_h);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            // sparse grid points: enough distinct cells to fill the tables
            x  = 2 * int'($urandom_range(0, w / 2));
            y  = 2 * int'($urandom_range(0, h / 2));
            sz = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 30)) : 1;
            add_rect(x, y, x + sz, y + sz, 1'($urandom));
        end else if (pick < 9) begin
            x = int'($urandom_range(0, w + 60)) - 30;
            y = int'($urandom_range(0, h + 60)) - 30;
            add_rect(x, y, x + int'($urandom_range(0, 300)) - 20,
                     y + int'($urandom_range(0, 300)) - 20, 1'($urandom));
        end else begin
            add_rect(int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                     int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                     1'($urandom));
        end
    endtask

    task random_read();
        read_slot($urandom_range(0, 1) ? int'($urandom_range(0, 7)) : int'($urandom_range(0, 63)));
    endtask

    task write_reg(drrl_pkg::t_cfg_reg idx, int data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= drrl_pkg::COORD_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, drrl_pkg::COORD_W'(data));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task random_phase(int quota);
        int target;
        int n;
        int pick;
        target = items_sent + quota;
        while (items_sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                n = $urandom_range(1, 90);
                repeat (n) random_add();
                n = $urandom_range(0, 4);
                repeat (n) random_read();
                plain_cmd(($urandom_range(0, 3) == 0) ? drrl_pkg::ACT_MARK
                                                      : drrl_pkg::ACT_ROTATE);
            end else if (pick < 8) begin
                n = $urandom_range(1, 8);
                repeat (n) random_read();
            end else if (pick == 8) begin
                plain_cmd(drrl_pkg::ACT_MARK);
                plain_cmd(drrl_pkg::ACT_ROTATE);
            end else begin
                n = $urandom_range(1, 5);
                repeat (n) send_cmd(random_cmd());
            end
        end
    endtask

    initial begin
        int phase_w[PHASES];
        int phase_h[PHASES];
        int phase_idle[PHASES];
        sb = new();
        phase_w    = '{2047, 640, 1, 2047, 0, 37};
        phase_h    = '{2047, 480, 2047, 1, 0, 23};
        phase_idle = '{19, 19, 66, 66, 0, 0};
        phase_w[4] = $urandom_range(1, 2047);
        phase_h[4] = $urandom_range(1, 2047);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 19;
        read_slot(0);
        add_rect(-2048, -2048, 2047, 2047, 1'b0);
        add_rect(10, 10, 10, 20, 1'b1);
        add_rect(700, 0, 800, 10, 1'b1);
        add_rect(2047, 2047, -2048, -2048, 1'b1);
        add_rect(5, 5, 6, 6, 1'b1);
        plain_cmd(drrl_pkg::ACT_ROTATE);
        read_slot(0);
        read_slot(63);
        plain_cmd(drrl_pkg::ACT_MARK);
        plain_cmd(drrl_pkg::ACT_ROTATE);
        read_slot(0);
        add_rect(0, 0, 1, 1, 1'b0);
        add_rect(1, 0, 2, 1, 1'b0);
        add_rect(0, 1, 1, 2, 1'b1);
        add_rect(4, 4, 5, 5, 1'b0);
        plain_cmd(drrl_pkg::ACT_ROTATE);
        read_slot(0);
        read_slot(1);
        read_slot(2);
        drain();

        // degenerate screen sizes
        write_reg(drrl_pkg::REG_SCREEN_WIDTH, 0);
        write_reg(drrl_pkg::REG_SCREEN_HEIGHT, 0);
        plain_cmd(drrl_pkg::ACT_MARK);
        plain_cmd(drrl_pkg::ACT_ROTATE);
        read_slot(0);
        add_rect(0, 0, 5, 5, 1'b1);
        drain();
        write_reg(drrl_pkg::REG_SCREEN_HEIGHT, 5);
        plain_cmd(drrl_pkg::ACT_MARK);
        plain_cmd(drrl_pkg::ACT_ROTATE);
        read_slot(0);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_reg(drrl_pkg::REG_SCREEN_WIDTH, phase_w[p]);
            write_reg(drrl_pkg::REG_SCREEN_HEIGHT, phase_h[p]);
            idle_pct = phase_idle[p];
            random_phase(PHASE_ITEMS);
        end

        drain();
        repeat (drrl_pkg::REGION_SLOTS + 8) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.pending.size()));
        end
        if (sb.mismatches == 0) begin
            $display("dirty_rectangle_region_list_test passed");
        end else begin
            $display("dirty_rectangle_region_list_test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/drrl_pkg.sv
sv/drrl_ctrl.sv
sv/drrl_datapath.sv
sv/dirty_rectangle_region_list.sv
tb/dirty_rectangle_region_list_test.sv
